>>> design/bsa_pkg.sv
// bsa_pkg: shared types, codes and bit-vector helpers of the bitmap slot allocator.
// No dependencies; imported by bitmap_slot_allocator_core and tb_top.
`timescale 1ns / 1ps

package bsa_pkg;

    // Bitmap word geometry
    localparam int WORD_W = 64;
    localparam int BIT_W  = 6;

    // Field widths fixed by the interface
    localparam int REQ_W    = 3;
    localparam int STATUS_W = 2;

    // Request codes
    localparam logic [REQ_W-1:0] REQ_ALLOC       = 3'd0;
    localparam logic [REQ_W-1:0] REQ_FREE        = 3'd1;
    localparam logic [REQ_W-1:0] REQ_QUERY       = 3'd2;
    localparam logic [REQ_W-1:0] REQ_EOF         = 3'd3;
    localparam logic [REQ_W-1:0] REQ_RELEASE_ALL = 3'd4;

    // Status codes
    localparam logic [STATUS_W-1:0] ST_OK         = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL       = 2'd1;
    localparam logic [STATUS_W-1:0] ST_BAD_HANDLE = 2'd2;

    typedef struct packed {
        logic             found;
        logic [BIT_W-1:0] idx;
    } first_set_t;

    // Lowest set bit of a bitmap word
    function automatic first_set_t first_set(input logic [WORD_W-1:0] bits);
        first_set_t r;
        r.found = 1'b0;
        r.idx   = '0;
        for (int i = WORD_W - 1; i >= 0; i--) begin
            if (bits[i])
            begin
                r.found = 1'b1;
                r.idx   = BIT_W'(i);
            end
        end
        return r;
    endfunction

    // Number of set bits in a word: per-byte counts, then a sum of the eight
    function automatic logic [BIT_W:0] popcount(input logic [WORD_W-1:0] bits);
        logic [3:0]     byte_cnt [WORD_W/8];
        logic [BIT_W:0] total;
        for (int b = 0; b < WORD_W / 8; b++) begin
            byte_cnt[b] = '0;
            for (int k = 0; k < 8; k++) begin
                byte_cnt[b] = byte_cnt[b] + 4'(bits[b*8+k]);
            end
        end
        total = '0;
        for (int b = 0; b < WORD_W / 8; b++) begin
            total = total + (BIT_W+1)'(byte_cnt[b]);
        end
        return total;
    endfunction

endpackage

>>> design/bitmap_slot_allocator_core.sv
// bitmap_slot_allocator_core: handle allocator over used / pending-free bitmaps.
// Depends on bsa_pkg (codes, word geometry, first-set and popcount helpers).
`timescale 1ns / 1ps

// A request beat is taken when start is high and busy is low; exactly one result
// follows, shown for a single cycle with done high, and it cannot be held off.
// Both bitmaps sit in word memories of 64 slots per word, walked one word per
// cycle by a single read port and a single write port. With NW = NUM_SLOTS/64
// words (rounded up): free and query read the handle's word on accept and answer
// from S_HANDLE; unused codes and allocate on a full hint answer straight from
// idle; allocate walks from the hint word to the first word with a free slot, at
// most NW words; end-of-frame and release-all always walk every word. After reset
// the block stays busy while both bitmaps are cleared.
module bitmap_slot_allocator_core #(
    parameter int NUM_SLOTS = 1024
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               start,
    output logic                               busy,
    input  logic [bsa_pkg::REQ_W-1:0]          req_type,
    input  logic [$clog2(NUM_SLOTS+1)-1:0]     entity_handle,
    output logic                               done,
    output logic [$clog2(NUM_SLOTS+1)-1:0]     new_handle,
    output logic                               handle_valid,
    output logic [bsa_pkg::STATUS_W-1:0]       status,
    output logic [$clog2(NUM_SLOTS+1)-1:0]     live_count
);

    import bsa_pkg::*;

    localparam int NW        = (NUM_SLOTS + WORD_W - 1) / WORD_W;
    localparam int HANDLE_W  = $clog2(NUM_SLOTS + 1);
    localparam int CNT_W     = $clog2(NW + 1);
    localparam int WA_W      = (NW > 1) ? $clog2(NW) : 1;
    localparam int POS_W     = CNT_W + BIT_W;
    localparam int LAST_BITS = NUM_SLOTS - (NW - 1) * WORD_W;

    localparam logic [WORD_W-1:0]   LAST_MASK = (LAST_BITS == WORD_W) ? '1 :
                                                ((WORD_W'(1) << LAST_BITS) - WORD_W'(1));
    localparam logic [CNT_W-1:0]    LAST_CNT  = CNT_W'(NW - 1);
    localparam logic [CNT_W-1:0]    NW_CNT    = CNT_W'(NW);
    localparam logic [HANDLE_W-1:0] MAX_H     = HANDLE_W'(NUM_SLOTS);

    typedef enum logic [4:0] {
        S_CLEAR  = 5'b00001,
        S_IDLE   = 5'b00010,
        S_ALLOC  = 5'b00100,
        S_HANDLE = 5'b01000,
        S_FRAME  = 5'b10000
    } state_t;

    // Bitmap memories, one word per row
    logic [WORD_W-1:0] used_mem [NW];
    logic [WORD_W-1:0] pend_mem [NW];
    logic [WORD_W-1:0] used_rd_reg;
    logic [WORD_W-1:0] pend_rd_reg;

    state_t               state_reg,        state_next;
    logic [CNT_W-1:0]     issue_cnt_reg,    issue_cnt_next;
    logic [CNT_W-1:0]     proc_cnt_reg,     proc_cnt_next;
    logic                 data_vld_reg,     data_vld_next;
    logic [REQ_W-1:0]     req_reg,          req_next;
    logic                 hok_reg,          hok_next;
    logic [BIT_W-1:0]     hbit_reg,         hbit_next;
    logic [HANDLE_W-1:0]  hint_reg,         hint_next;
    logic [HANDLE_W-1:0]  count_reg,        count_next;
    logic                 done_reg,         done_next;
    logic [HANDLE_W-1:0]  new_handle_reg,   new_handle_next;
    logic                 handle_valid_reg, handle_valid_next;
    logic [STATUS_W-1:0]  status_reg,       status_next;

    // Memory port controls
    logic              rd_en;
    logic [WA_W-1:0]   rd_addr;
    logic              used_we;
    logic              pend_we;
    logic [WA_W-1:0]   wr_addr;
    logic [WORD_W-1:0] used_wdata;
    logic [WORD_W-1:0] pend_wdata;

    // Handle decode
    logic [POS_W-1:0] h_pos;
    logic             h_ok;
    logic [CNT_W-1:0] h_cnt;

    // Hint split into word and bit
    logic [POS_W-1:0] hint_pos;
    logic [CNT_W-1:0] hint_cnt;
    logic [BIT_W-1:0] hint_bit;

    // Word evaluation
    logic [WORD_W-1:0] range_mask;
    logic [WORD_W-1:0] low_mask;
    logic [WORD_W-1:0] free_bits;
    first_set_t        free_first;
    logic [POS_W-1:0]  free_pos;
    logic [WORD_W-1:0] rel_bits;
    first_set_t        rel_first;
    logic [POS_W-1:0]  rel_pos;
    logic [BIT_W:0]    rel_cnt;
    logic              issue_more;
    logic              used_bit;

    assign h_pos    = POS_W'(entity_handle) - POS_W'(1);
    assign h_ok     = (entity_handle != '0) && (entity_handle <= MAX_H);
    assign h_cnt    = h_ok ? h_pos[POS_W-1:BIT_W] : '0;

    assign hint_pos = POS_W'(hint_reg);
    assign hint_cnt = hint_pos[POS_W-1:BIT_W];
    assign hint_bit = hint_pos[BIT_W-1:0];

    // Allocate: free bits in range and at or above the hint
    assign range_mask = (proc_cnt_reg == LAST_CNT) ? LAST_MASK : '1;
    assign low_mask   = (proc_cnt_reg == hint_cnt) ? ('1 << hint_bit) : '1;
    assign free_bits  = ~used_rd_reg & range_mask & low_mask;
    assign free_first = first_set(free_bits);
    assign free_pos   = {proc_cnt_reg, free_first.idx};

    // End of frame: used slots that are pending (all used on release-all)
    assign rel_bits  = used_rd_reg & ((req_reg == REQ_RELEASE_ALL) ? '1 : pend_rd_reg);
    assign rel_first = first_set(rel_bits);
    assign rel_pos   = {proc_cnt_reg, rel_first.idx};
    assign rel_cnt   = popcount(rel_bits);

    assign issue_more = issue_cnt_reg < NW_CNT;
    assign used_bit   = used_rd_reg[hbit_reg];

    // Sequencer
    always_comb
    begin
        state_next        = state_reg;
        issue_cnt_next    = issue_cnt_reg;
        proc_cnt_next     = issue_cnt_reg;
        data_vld_next     = 1'b0;
        req_next          = req_reg;
        hok_next          = hok_reg;
        hbit_next         = hbit_reg;
        hint_next         = hint_reg;
        count_next        = count_reg;
        done_next         = 1'b0;
        new_handle_next   = new_handle_reg;
        handle_valid_next = handle_valid_reg;
        status_next       = status_reg;

        rd_en      = 1'b0;
        rd_addr    = issue_cnt_reg[WA_W-1:0];
        used_we    = 1'b0;
        pend_we    = 1'b0;
        wr_addr    = proc_cnt_reg[WA_W-1:0];
        used_wdata = '0;
        pend_wdata = '0;

        unique case (state_reg)
            // Zero one row of both bitmaps per cycle
            S_CLEAR:
            begin
                used_we        = 1'b1;
                pend_we        = 1'b1;
                wr_addr        = issue_cnt_reg[WA_W-1:0];
                issue_cnt_next = issue_cnt_reg + CNT_W'(1);
                if (issue_cnt_reg == LAST_CNT)
                begin
                    issue_cnt_next = '0;
                    state_next     = S_IDLE;
                end
            end

            S_IDLE:
            begin
                if (start)
                begin
                    req_next          = req_type;
                    new_handle_next   = '0;
                    handle_valid_next = 1'b0;
                    status_next       = ST_OK;
                    unique case (req_type)
                        REQ_ALLOC:
                        begin
                            if (hint_cnt >= NW_CNT)
                            begin
                                status_next = ST_FULL;
                                done_next   = 1'b1;
                            end
                            else
                            begin
                                issue_cnt_next = hint_cnt;
                                state_next     = S_ALLOC;
                            end
                        end
                        REQ_FREE, REQ_QUERY:
                        begin
                            rd_en          = 1'b1;
                            rd_addr        = h_cnt[WA_W-1:0];
                            issue_cnt_next = h_cnt;
                            hok_next       = h_ok;
                            hbit_next      = h_pos[BIT_W-1:0];
                            state_next     = S_HANDLE;
                        end
                        REQ_EOF, REQ_RELEASE_ALL:
                        begin
                            issue_cnt_next = '0;
                            state_next     = S_FRAME;
                        end
                        default:
                        begin
                            done_next = 1'b1;
                        end
                    endcase
                end
            end

            // Walk words from the hint word until a free slot turns up or the last word is full
            S_ALLOC:
            begin
                rd_en         = issue_more;
                data_vld_next = issue_more;
                if (issue_more)
                begin
                    issue_cnt_next = issue_cnt_reg + CNT_W'(1);
                end
                if (data_vld_reg)
                begin
                    if (free_first.found)
                    begin
                        used_we         = 1'b1;
                        used_wdata      = used_rd_reg | (WORD_W'(1) << free_first.idx);
                        hint_next       = HANDLE_W'(free_pos + POS_W'(1));
                        count_next      = count_reg + HANDLE_W'(1);
                        new_handle_next = HANDLE_W'(free_pos + POS_W'(1));
                        done_next       = 1'b1;
                        data_vld_next   = 1'b0;
                        state_next      = S_IDLE;
                    end
                    else if (proc_cnt_reg == LAST_CNT)
                    begin
                        status_next   = ST_FULL;
                        done_next     = 1'b1;
                        data_vld_next = 1'b0;
                        state_next    = S_IDLE;
                    end
                end
            end

            // Free or query: the handle's word was read on accept
            S_HANDLE:
            begin
                if (req_reg == REQ_FREE)
                begin
                    if (hok_reg && used_bit)
                    begin
                        pend_we    = 1'b1;
                        wr_addr    = issue_cnt_reg[WA_W-1:0];
                        pend_wdata = pend_rd_reg | (WORD_W'(1) << hbit_reg);
                    end
                    else
                    begin
                        status_next = ST_BAD_HANDLE;
                    end
                end
                else
                begin
                    handle_valid_next = hok_reg && used_bit;
                end
                done_next  = 1'b1;
                state_next = S_IDLE;
            end

            // Release pending slots (all used slots on release-all) word by word, lowering count and hint
            S_FRAME:
            begin
                rd_en         = issue_more;
                data_vld_next = issue_more;
                if (issue_more)
                begin
                    issue_cnt_next = issue_cnt_reg + CNT_W'(1);
                end
                if (data_vld_reg)
                begin
                    used_we    = 1'b1;
                    pend_we    = 1'b1;
                    used_wdata = used_rd_reg & ~rel_bits;
                    pend_wdata = '0;
                    count_next = count_reg - HANDLE_W'(rel_cnt);
                    if (rel_first.found && (rel_pos < hint_pos))
                    begin
                        hint_next = HANDLE_W'(rel_pos);
                    end
                    if (proc_cnt_reg == LAST_CNT)
                    begin
                        done_next     = 1'b1;
                        data_vld_next = 1'b0;
                        state_next    = S_IDLE;
                    end
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control and result registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_CLEAR;
            issue_cnt_reg    <= '0;
            proc_cnt_reg     <= '0;
            data_vld_reg     <= 1'b0;
            req_reg          <= REQ_ALLOC;
            hok_reg          <= 1'b0;
            hbit_reg         <= '0;
            hint_reg         <= '0;
            count_reg        <= '0;
            done_reg         <= 1'b0;
            new_handle_reg   <= '0;
            handle_valid_reg <= 1'b0;
            status_reg       <= ST_OK;
        end
        else
        begin
            state_reg        <= state_next;
            issue_cnt_reg    <= issue_cnt_next;
            proc_cnt_reg     <= proc_cnt_next;
            data_vld_reg     <= data_vld_next;
            req_reg          <= req_next;
            hok_reg          <= hok_next;
            hbit_reg         <= hbit_next;
            hint_reg         <= hint_next;
            count_reg        <= count_next;
            done_reg         <= done_next;
            new_handle_reg   <= new_handle_next;
            handle_valid_reg <= handle_valid_next;
            status_reg       <= status_next;
        end
    end

    // Bitmap memories: one write and one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (used_we)
        begin
            used_mem[wr_addr] <= used_wdata;
        end
        if (pend_we)
        begin
            pend_mem[wr_addr] <= pend_wdata;
        end
        if (rd_en)
        begin
            used_rd_reg <= used_mem[rd_addr];
            pend_rd_reg <= pend_mem[rd_addr];
        end
    end

    assign busy         = (state_reg != S_IDLE);
    assign done         = done_reg;
    assign new_handle   = new_handle_reg;
    assign handle_valid = handle_valid_reg;
    assign status       = status_reg;
    assign live_count   = count_reg;

endmodule

>>> verif/tb_top.sv
// tb_top: self-checking bench for bitmap_slot_allocator_core over its start/busy command port.
// Depends on bsa_pkg and bitmap_slot_allocator_core; keeps its own slot table to predict replies.
`timescale 1ns / 1ps

module tb_top;
    import bsa_pkg::*;

    localparam int NUM_SLOTS     = 1024;
    localparam int HW            = $clog2(NUM_SLOTS + 1);
    localparam int NW            = (NUM_SLOTS + WORD_W - 1) / WORD_W;
    localparam int SETTLE_CYCLES = NW + 8;
    localparam int CYCLE_LIMIT   = 600000;
    localparam int MAX_REPORTS   = 40;
    localparam int MAX_GAP       = 40;

    localparam logic [HW-1:0] TOP_HANDLE = HW'(NUM_SLOTS);
    localparam logic [HW-1:0] ALL_ONES   = '1;

    // request codes the block ignores
    localparam logic [REQ_W-1:0] REQ_UNUSED_LO  = 3'd5;
    localparam logic [REQ_W-1:0] REQ_UNUSED_MID = 3'd6;
    localparam logic [REQ_W-1:0] REQ_UNUSED_HI  = 3'd7;

    typedef struct packed {
        logic [HW-1:0]       new_handle;
        logic                handle_valid;
        logic [STATUS_W-1:0] status;
        logic [HW-1:0]       live_count;
    } reply_t;

    logic                clk           = 1'b0;
    logic                rst_n         = 1'b0;
    logic                start         = 1'b0;
    logic [REQ_W-1:0]    req_type      = REQ_ALLOC;
    logic [HW-1:0]       entity_handle = '0;
    logic                busy;
    logic                done;
    logic [HW-1:0]       new_handle;
    logic                handle_valid;
    logic [STATUS_W-1:0] status;
    logic [HW-1:0]       live_count;

    // shadow slot table
    logic          shadow_used [NUM_SLOTS];
    logic          shadow_pend [NUM_SLOTS];
    logic [HW-1:0] shadow_hint;
    logic [HW-1:0] shadow_live;

    reply_t        slot_replies [$];
    logic [HW-1:0] granted_handles [$];

    int unsigned sender_idle_pct = 0;
    int unsigned accepted_count  = 0;
    int unsigned alloc_count     = 0;
    int unsigned full_count      = 0;
    int unsigned frame_count     = 0;
    int unsigned checked_count   = 0;
    int unsigned fail_count      = 0;
    int unsigned cycle_count     = 0;

    always #1 clk = ~clk;

    bitmap_slot_allocator_core #(
        .NUM_SLOTS(NUM_SLOTS)
    ) u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .req_type     (req_type),
        .entity_handle(entity_handle),
        .done         (done),
        .new_handle   (new_handle),
        .handle_valid (handle_valid),
        .status       (status),
        .live_count   (live_count)
    );

    function automatic void clear_slot_table();
        for (int i = 0; i < NUM_SLOTS; i++)
        begin
            shadow_used[i] = 1'b0;
            shadow_pend[i] = 1'b0;
        end
        shadow_hint = '0;
        shadow_live = '0;
    endfunction

    // zero and out-of-range handles are never in use
    function automatic logic handle_in_use(input logic [HW-1:0] h);
        if (h == '0 || h > TOP_HANDLE)
            return 1'b0;
        return shadow_used[h - 1'b1];
    endfunction

    // frame end: drop pending slots, pull the hint down, lower the count once per slot
    function automatic void release_pending();
        for (int i = 0; i < NUM_SLOTS; i++)
        begin
            if (shadow_pend[i])
            begin
                shadow_pend[i] = 1'b0;
                if (shadow_used[i])
                begin
                    shadow_used[i] = 1'b0;
                    if (shadow_live != '0)
                        shadow_live = shadow_live - 1'b1;
                    if (i < shadow_hint)
                        shadow_hint = HW'(i);
                end
            end
        end
    endfunction

    // one request against the shadow table; returns the reply it owes
    function automatic reply_t slot_table_step(input logic [REQ_W-1:0] op,
                                               input logic [HW-1:0]    h);
        reply_t r;
        int     slot;
        r = '0;
        case (op)
            REQ_ALLOC:
            begin
                slot = int'(shadow_hint);
                while (slot < NUM_SLOTS && shadow_used[slot])
                    slot++;
                if (slot < NUM_SLOTS)
                begin
                    shadow_used[slot] = 1'b1;
                    shadow_hint       = HW'(slot + 1);
                    shadow_live       = shadow_live + 1'b1;
                    r.new_handle      = HW'(slot + 1);
                end
                else
                    r.status = ST_FULL;
            end
            REQ_FREE:
            begin
                if (handle_in_use(h))
                    shadow_pend[h - 1'b1] = 1'b1;
                else
                    r.status = ST_BAD_HANDLE;
            end
            REQ_QUERY:
                r.handle_valid = handle_in_use(h);
            REQ_EOF:
                release_pending();
            REQ_RELEASE_ALL:
            begin
                for (int i = 0; i < NUM_SLOTS; i++)
                begin
                    if (shadow_used[i])
                        shadow_pend[i] = 1'b1;
                end
                release_pending();
            end
            default:
                r = '0;
        endcase
        r.live_count = shadow_live;
        return r;
    endfunction

    // Send one request beat after a random idle gap. start is left high on
    // acceptance so back-to-back beats never toggle it within one step.
    task automatic send_request(input  logic [REQ_W-1:0] op,
                                input  logic [HW-1:0]    h,
                                output reply_t           reply);
        int gap;
        gap = 0;
        while ($urandom_range(0, 99) < sender_idle_pct && gap < MAX_GAP)
            gap++;
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start         <= 1'b1;
        req_type      <= op;
        entity_handle <= h;
        @(posedge clk);
        while (busy !== 1'b0)
            @(posedge clk);
        reply = slot_table_step(op, h);
        slot_replies = {slot_replies, reply};
        accepted_count++;
        if (op == REQ_ALLOC)
            alloc_count++;
        if (reply.status == ST_FULL)
            full_count++;
        if (op == REQ_EOF || op == REQ_RELEASE_ALL)
            frame_count++;
    endtask

    task automatic wait_all_replies();
        start <= 1'b0;
        while (slot_replies.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // invalid handles, duplicate free, pending query, hint lowering, unused codes
    task automatic test_directed_cases();
        reply_t r;
        send_request(REQ_QUERY, '0, r);
        send_request(REQ_FREE, '0, r);
        send_request(REQ_FREE, ALL_ONES, r);
        send_request(REQ_QUERY, TOP_HANDLE, r);
        send_request(REQ_ALLOC, ALL_ONES, r);
        send_request(REQ_ALLOC, '0, r);
        send_request(REQ_ALLOC, '0, r);
        send_request(REQ_QUERY, 11'd2, r);
        send_request(REQ_FREE, 11'd2, r);
        send_request(REQ_FREE, 11'd2, r);
        send_request(REQ_QUERY, 11'd2, r);
        send_request(REQ_FREE, 11'd5, r);
        send_request(REQ_EOF, '0, r);
        send_request(REQ_QUERY, 11'd2, r);
        send_request(REQ_ALLOC, '0, r);
        send_request(REQ_UNUSED_LO, TOP_HANDLE, r);
        send_request(REQ_UNUSED_MID, ALL_ONES, r);
        send_request(REQ_UNUSED_HI, 11'd1, r);
        send_request(REQ_FREE, 11'd1, r);
        send_request(REQ_FREE, 11'd3, r);
        send_request(REQ_RELEASE_ALL, ALL_ONES, r);
        send_request(REQ_EOF, '0, r);
        send_request(REQ_ALLOC, '0, r);
        send_request(REQ_QUERY, ALL_ONES, r);
    endtask

    // mostly allocate / free-of-granted / frame-end traffic, some noise handles and codes
    task automatic test_random_traffic(input int unsigned idle_pct, input int unsigned count);
        reply_t        r;
        int            pick;
        int            k;
        logic [HW-1:0] h;
        sender_idle_pct = idle_pct;
        repeat (count)
        begin
            pick = $urandom_range(0, 99);
            h    = HW'($urandom_range(0, (1 << HW) - 1));
            if (pick < 40)
            begin
                send_request(REQ_ALLOC, h, r);
                if (r.new_handle != '0)
                    granted_handles = {granted_handles, r.new_handle};
            end
            else if (pick < 62 && granted_handles.size() > 0)
            begin
                // keep some freed handles around to provoke duplicate frees
                k = $urandom_range(0, granted_handles.size() - 1);
                h = granted_handles[k];
                if ($urandom_range(0, 3) != 0)
                    granted_handles.delete(k);
                send_request(REQ_FREE, h, r);
            end
            else if (pick < 74 && granted_handles.size() > 0)
            begin
                k = $urandom_range(0, granted_handles.size() - 1);
                send_request(REQ_QUERY, granted_handles[k], r);
            end
            else if (pick < 82)
                send_request(REQ_FREE, h, r);
            else if (pick < 87)
                send_request(REQ_QUERY, h, r);
            else if (pick < 94)
                send_request(REQ_EOF, h, r);
            else if (pick < 95)
            begin
                send_request(REQ_RELEASE_ALL, h, r);
                granted_handles.delete();
            end
            else
                send_request(REQ_W'($urandom_range(REQ_UNUSED_LO, REQ_UNUSED_HI)), h, r);
        end
    endtask

    // fill every slot, hit the full store, then reopen holes low and high
    task automatic test_full_store();
        reply_t r;
        send_request(REQ_RELEASE_ALL, '0, r);
        granted_handles.delete();
        for (int n = 0; n <= NUM_SLOTS && shadow_live < TOP_HANDLE; n++)
            send_request(REQ_ALLOC, HW'($urandom_range(0, (1 << HW) - 1)), r);
        send_request(REQ_ALLOC, '0, r);
        send_request(REQ_ALLOC, ALL_ONES, r);
        send_request(REQ_QUERY, TOP_HANDLE, r);
        send_request(REQ_FREE, TOP_HANDLE, r);
        send_request(REQ_FREE, 11'd1, r);
        send_request(REQ_FREE, 11'd700, r);
        send_request(REQ_FREE, 11'd700, r);
        send_request(REQ_ALLOC, '0, r);
        send_request(REQ_EOF, '0, r);
        send_request(REQ_ALLOC, '0, r);
        send_request(REQ_ALLOC, '0, r);
        send_request(REQ_ALLOC, '0, r);
        send_request(REQ_ALLOC, '0, r);
        send_request(REQ_FREE, ALL_ONES, r);
        send_request(REQ_RELEASE_ALL, '0, r);
    endtask

    function automatic void check_field(input string         field,
                                        input logic [HW-1:0] want,
                                        input logic [HW-1:0] got);
        if (got !== want)
        begin
            fail_count++;
            if (fail_count <= MAX_REPORTS)
                $error("%s: expected %0d, got %0d", field, want, got);
        end
    endfunction

    // every done beat must match the oldest owed reply
    always @(posedge clk)
    begin : reply_check
        reply_t want;
        if (rst_n === 1'b1 && done === 1'b1)
        begin
            if (slot_replies.size() == 0)
            begin
                fail_count++;
                if (fail_count <= MAX_REPORTS)
                    $error("result beat with none outstanding: new_handle %0d", new_handle);
            end
            else
            begin
                want = slot_replies.pop_front();
                checked_count++;
                check_field("new_handle", want.new_handle, new_handle);
                check_field("handle_valid", HW'(want.handle_valid), HW'(handle_valid));
                check_field("status", HW'(want.status), HW'(status));
                check_field("live_count", want.live_count, live_count);
            end
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d replies outstanding",
                     cycle_count, slot_replies.size());
            $display("tb_top NOT OK");
            $finish;
        end
    end

    initial
    begin
        clear_slot_table();
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        test_directed_cases();
        test_random_traffic(33, 210);
        test_random_traffic(88, 210);
        test_random_traffic(0, 200);
        test_full_store();
        wait_all_replies();
        $display("Covered %0d requests: %0d allocations (%0d on a full store), %0d frame ends.",
                 accepted_count, alloc_count, full_count, frame_count);
        $display("%0d replies compared field by field, %0d failures.",
                 checked_count, fail_count);
        if (fail_count == 0)
            $display("tb_top OK");
        else
            $display("tb_top NOT OK");
        $finish;
    end

endmodule

>>> files.f
design/bsa_pkg.sv
design/bitmap_slot_allocator_core.sv
verif/tb_top.sv
